FILE: design/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared widths, types and helpers for the rectangle clip / subtract block.
// ----------------------------------------------------------------------------
package rcs_pkg;

    // Coordinate width inside the datapath; port fields stay 32 bits
    localparam int COORD_BITS    = 32;
    localparam int FIELD_BITS    = 32;
    localparam int IN_FIELDS     = 8;
    localparam int OUT_FIELDS    = 4;
    localparam int IN_DATA_BITS  = IN_FIELDS * FIELD_BITS;
    localparam int OUT_DATA_BITS = OUT_FIELDS * FIELD_BITS;
    localparam int MAX_PIECES    = 4;

    // Operation codes carried on the input tuser
    localparam logic MODE_CLIP = 1'b0;
    localparam logic MODE_SUB  = 1'b1;

    // Slot of each subtract piece, in output order
    localparam int PIECE_TOP    = 0;
    localparam int PIECE_BOTTOM = 1;
    localparam int PIECE_LEFT   = 2;
    localparam int PIECE_RIGHT  = 3;

    typedef logic signed [FIELD_BITS-1:0] t_field;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_ext;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord w;
        t_coord h;
    } t_rect;

    // Registered input transaction
    typedef struct packed {
        logic  mode;
        t_rect a;
        t_rect b;
    } t_in_item;

    // After end-coordinate sums
    typedef struct packed {
        logic  mode;
        t_rect a;
        t_rect b;
        t_ext  ar;
        t_ext  ab;
        t_ext  br;
        t_ext  bb;
        logic  a_empty;
        logic  b_empty;
    } t_bounds;

    // After overlap edges are picked
    typedef struct packed {
        logic   mode;
        t_rect  a;
        t_coord ar;
        t_coord ab;
        t_coord l;
        t_coord t;
        t_coord r;
        t_coord bo;
        logic   pre_ok;
        logic   a_empty;
    } t_overlap;

    // Result group: up to four rectangles with a mask of the ones to send
    typedef struct packed {
        t_rect [MAX_PIECES-1:0] rects;
        logic  [MAX_PIECES-1:0] mask;
        logic                   res_valid;
    } t_group;

    function automatic t_ext to_ext(input t_coord c);
        return {c[COORD_BITS-1], c};
    endfunction

    // A widened value fits the coordinate range when its top two bits agree
    function automatic logic fits(input t_ext v);
        return v[COORD_BITS] == v[COORD_BITS-1];
    endfunction

    function automatic t_coord to_coord(input t_field f);
        return f[COORD_BITS-1:0];
    endfunction

    function automatic t_field to_field(input t_coord c);
        return t_field'(c);
    endfunction

    function automatic logic is_empty(input t_rect rc);
        return (rc.w <= t_coord'(0)) || (rc.h <= t_coord'(0));
    endfunction

endpackage

FILE: design/rcs_bounds.sv
// ----------------------------------------------------------------------------
// rcs_bounds
// Right and bottom edges of both rectangles and their empty flags.
// ----------------------------------------------------------------------------
module rcs_bounds (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rcs_pkg::t_in_item i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output rcs_pkg::t_bounds o_bounds
);

    logic             r_valid;
    rcs_pkg::t_bounds r_bounds;
    rcs_pkg::t_bounds n_bounds;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_bounds = r_bounds;

    // Edge sums, one bit wider so overflow shows
    always_comb begin
        n_bounds.mode    = i_item.mode;
        n_bounds.a       = i_item.a;
        n_bounds.b       = i_item.b;
        n_bounds.ar      = rcs_pkg::to_ext(i_item.a.x) + rcs_pkg::to_ext(i_item.a.w);
        n_bounds.ab      = rcs_pkg::to_ext(i_item.a.y) + rcs_pkg::to_ext(i_item.a.h);
        n_bounds.br      = rcs_pkg::to_ext(i_item.b.x) + rcs_pkg::to_ext(i_item.b.w);
        n_bounds.bb      = rcs_pkg::to_ext(i_item.b.y) + rcs_pkg::to_ext(i_item.b.h);
        n_bounds.a_empty = rcs_pkg::is_empty(i_item.a);
        n_bounds.b_empty = rcs_pkg::is_empty(i_item.b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bounds <= n_bounds;
        end
    end

endmodule

FILE: design/rcs_overlap.sv
// ----------------------------------------------------------------------------
// rcs_overlap
// Picks the overlap edges and checks the edge sums for overflow.
// ----------------------------------------------------------------------------
module rcs_overlap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rcs_pkg::t_bounds  i_bounds,
    output logic              o_valid,
    input  logic              i_ready,
    output rcs_pkg::t_overlap o_overlap
);

    logic              r_valid;
    rcs_pkg::t_overlap r_overlap;
    rcs_pkg::t_overlap n_overlap;
    rcs_pkg::t_ext     n_r;
    rcs_pkg::t_ext     n_bo;
    logic              n_ends_ok;

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_overlap = r_overlap;

    // max of the near edges, min of the far edges
    always_comb begin
        n_r  = (i_bounds.ar < i_bounds.br) ? i_bounds.ar : i_bounds.br;
        n_bo = (i_bounds.ab < i_bounds.bb) ? i_bounds.ab : i_bounds.bb;
        n_ends_ok = rcs_pkg::fits(i_bounds.ar) && rcs_pkg::fits(i_bounds.ab)
                 && rcs_pkg::fits(i_bounds.br) && rcs_pkg::fits(i_bounds.bb);

        n_overlap.mode    = i_bounds.mode;
        n_overlap.a       = i_bounds.a;
        n_overlap.ar      = i_bounds.ar[rcs_pkg::COORD_BITS-1:0];
        n_overlap.ab      = i_bounds.ab[rcs_pkg::COORD_BITS-1:0];
        n_overlap.l       = (i_bounds.a.x > i_bounds.b.x) ? i_bounds.a.x : i_bounds.b.x;
        n_overlap.t       = (i_bounds.a.y > i_bounds.b.y) ? i_bounds.a.y : i_bounds.b.y;
        n_overlap.r       = n_r[rcs_pkg::COORD_BITS-1:0];
        n_overlap.bo      = n_bo[rcs_pkg::COORD_BITS-1:0];
        n_overlap.pre_ok  = n_ends_ok && !i_bounds.a_empty && !i_bounds.b_empty;
        n_overlap.a_empty = i_bounds.a_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_overlap <= n_overlap;
        end
    end

endmodule

FILE: design/rcs_pieces.sv
// ----------------------------------------------------------------------------
// rcs_pieces
// Final clip check and the result rectangles for either mode.
// ----------------------------------------------------------------------------
module rcs_pieces (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rcs_pkg::t_overlap i_overlap,
    output logic              o_valid,
    input  logic              i_ready,
    output rcs_pkg::t_group   o_group
);

    logic            r_valid;
    rcs_pkg::t_group r_group;
    rcs_pkg::t_group n_group;
    rcs_pkg::t_ext   n_ow;
    rcs_pkg::t_ext   n_oh;
    rcs_pkg::t_coord n_ow_c;
    rcs_pkg::t_coord n_oh_c;
    logic            n_ok;
    rcs_pkg::t_rect  n_clip;
    rcs_pkg::t_rect  n_top;
    rcs_pkg::t_rect  n_bot;
    rcs_pkg::t_rect  n_left;
    rcs_pkg::t_rect  n_right;
    logic [rcs_pkg::MAX_PIECES-1:0] n_mask;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_group = r_group;

    always_comb begin
        // overlap size and clip verdict
        n_ow   = rcs_pkg::to_ext(i_overlap.r) - rcs_pkg::to_ext(i_overlap.l);
        n_oh   = rcs_pkg::to_ext(i_overlap.bo) - rcs_pkg::to_ext(i_overlap.t);
        n_ow_c = n_ow[rcs_pkg::COORD_BITS-1:0];
        n_oh_c = n_oh[rcs_pkg::COORD_BITS-1:0];
        n_ok   = i_overlap.pre_ok && (n_ow > rcs_pkg::t_ext'(0)) && (n_oh > rcs_pkg::t_ext'(0))
              && rcs_pkg::fits(n_ow) && rcs_pkg::fits(n_oh);

        n_clip = '{x: i_overlap.l, y: i_overlap.t, w: n_ow_c, h: n_oh_c};

        // subtract pieces; differences stay inside A so they wrap correctly
        n_top   = '{x: i_overlap.a.x, y: i_overlap.a.y, w: i_overlap.a.w,
                    h: i_overlap.t - i_overlap.a.y};
        n_bot   = '{x: i_overlap.a.x, y: i_overlap.bo, w: i_overlap.a.w,
                    h: i_overlap.ab - i_overlap.bo};
        n_left  = '{x: i_overlap.a.x, y: i_overlap.t,
                    w: i_overlap.l - i_overlap.a.x, h: n_oh_c};
        n_right = '{x: i_overlap.r, y: i_overlap.t,
                    w: i_overlap.ar - i_overlap.r, h: n_oh_c};

        n_mask = '0;
        n_mask[rcs_pkg::PIECE_TOP]    = i_overlap.t > i_overlap.a.y;
        n_mask[rcs_pkg::PIECE_BOTTOM] = i_overlap.bo < i_overlap.ab;
        n_mask[rcs_pkg::PIECE_LEFT]   = i_overlap.l > i_overlap.a.x;
        n_mask[rcs_pkg::PIECE_RIGHT]  = i_overlap.r < i_overlap.ar;

        // default: one invalid, all-zero result
        n_group.rects     = '0;
        n_group.mask      = rcs_pkg::MAX_PIECES'(1);
        n_group.res_valid = 1'b0;

        if (i_overlap.mode == rcs_pkg::MODE_CLIP) begin
            if (n_ok) begin
                n_group.rects[0]  = n_clip;
                n_group.res_valid = 1'b1;
            end
        end else if (!i_overlap.a_empty) begin
            if (!n_ok) begin
                // no valid overlap with B (disjoint, empty B or overflow): A goes out whole
                n_group.rects[0]  = i_overlap.a;
                n_group.res_valid = 1'b1;
            end else if (n_mask != '0) begin
                n_group.rects[rcs_pkg::PIECE_TOP]    = n_top;
                n_group.rects[rcs_pkg::PIECE_BOTTOM] = n_bot;
                n_group.rects[rcs_pkg::PIECE_LEFT]   = n_left;
                n_group.rects[rcs_pkg::PIECE_RIGHT]  = n_right;
                n_group.mask      = n_mask;
                n_group.res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_group <= n_group;
        end
    end

endmodule

FILE: design/rcs_emit.sv
// ----------------------------------------------------------------------------
// rcs_emit
// Holds one result group and sends its rectangles one per cycle through
// the output register while it is not stalled, lowest slot first.
// ----------------------------------------------------------------------------
module rcs_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rcs_pkg::t_group                   i_group,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rcs_pkg::OUT_DATA_BITS-1:0] o_data,
    output logic                              o_last,
    output logic                              o_res_valid
);

    logic                              r_grp_valid;
    rcs_pkg::t_group                   r_grp;
    logic                              r_out_valid;
    logic [rcs_pkg::OUT_DATA_BITS-1:0] r_out_data;
    logic                              r_out_last;
    logic                              r_out_res_valid;

    logic [rcs_pkg::MAX_PIECES-1:0] n_low;
    logic [rcs_pkg::MAX_PIECES-1:0] n_rest;
    rcs_pkg::t_rect                 n_rect;
    logic                           n_load;
    logic                           n_done;

    // pick the lowest pending slot
    always_comb begin
        n_low  = r_grp.mask & (~r_grp.mask + rcs_pkg::MAX_PIECES'(1));
        n_rest = r_grp.mask & ~n_low;
        n_rect = '0;
        for (int i = 0; i < rcs_pkg::MAX_PIECES; i++) begin
            if (n_low[i]) begin
                n_rect = r_grp.rects[i];
            end
        end
    end

    assign n_load  = r_grp_valid && (!r_out_valid || i_ready);
    assign n_done  = n_rest == '0;
    assign o_ready = !r_grp_valid || (n_load && n_done);

    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_last      = r_out_last;
    assign o_res_valid = r_out_res_valid;

    // group holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
        end else if (o_ready) begin
            r_grp_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_grp <= i_group;
        end else if (n_load) begin
            r_grp.mask <= n_rest;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_data      <= {rcs_pkg::to_field(n_rect.h), rcs_pkg::to_field(n_rect.w),
                                rcs_pkg::to_field(n_rect.y), rcs_pkg::to_field(n_rect.x)};
            r_out_last      <= n_done;
            r_out_res_valid <= r_grp.res_valid;
        end
    end

endmodule

FILE: design/rect_clip_and_subtract.sv
// ----------------------------------------------------------------------------
// rect_clip_and_subtract
// Intersection (clip) or difference (subtract) of two axis-aligned signed
// rectangles, with one to four result rectangles per input transaction.
//
//  channel  dir  tdata (low bit up)                       tuser      tlast
//  s_axis   in   a_x a_y a_w a_h b_x b_y b_w b_h (256b)   mode       -
//  m_axis   out  res_x res_y res_w res_h (128b)           res_valid  res_last
//
// Input register, three short compute stages and a result group register
// feed one output register. The output register sends one result per cycle
// while m_axis is not stalled; an item gives one result for clip and one to
// four for subtract. Reset (synchronous, active low) empties every stage.
// A stall on m_axis backs up stage by stage; s_axis keeps taking items
// while stages are free.
// ----------------------------------------------------------------------------
module rect_clip_and_subtract (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
    input  logic [rcs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // res_x, res_y, res_w, res_h
    output logic [rcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // res_valid
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int FB = rcs_pkg::FIELD_BITS;

    logic              r_in_valid;
    rcs_pkg::t_in_item r_in;
    rcs_pkg::t_in_item n_in;
    logic              in_ready;

    logic              bnd_valid;
    logic              bnd_ready;
    logic              ovl_ready;
    logic              ovl_valid;
    logic              pcs_ready;
    logic              pcs_valid;
    logic              emt_ready;
    rcs_pkg::t_bounds  bnd;
    rcs_pkg::t_overlap ovl;
    rcs_pkg::t_group   grp;

    // unpack the input transaction
    always_comb begin
        n_in.mode = s_axis_tuser;
        n_in.a.x  = rcs_pkg::to_coord(s_axis_tdata[0*FB +: FB]);
        n_in.a.y  = rcs_pkg::to_coord(s_axis_tdata[1*FB +: FB]);
        n_in.a.w  = rcs_pkg::to_coord(s_axis_tdata[2*FB +: FB]);
        n_in.a.h  = rcs_pkg::to_coord(s_axis_tdata[3*FB +: FB]);
        n_in.b.x  = rcs_pkg::to_coord(s_axis_tdata[4*FB +: FB]);
        n_in.b.y  = rcs_pkg::to_coord(s_axis_tdata[5*FB +: FB]);
        n_in.b.w  = rcs_pkg::to_coord(s_axis_tdata[6*FB +: FB]);
        n_in.b.h  = rcs_pkg::to_coord(s_axis_tdata[7*FB +: FB]);
    end

    // input register
    assign in_ready      = !r_in_valid || bnd_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    rcs_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (bnd_ready),
        .i_item   (r_in),
        .o_valid  (bnd_valid),
        .i_ready  (ovl_ready),
        .o_bounds (bnd)
    );

    rcs_overlap u_overlap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (bnd_valid),
        .o_ready   (ovl_ready),
        .i_bounds  (bnd),
        .o_valid   (ovl_valid),
        .i_ready   (pcs_ready),
        .o_overlap (ovl)
    );

    rcs_pieces u_pieces (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (ovl_valid),
        .o_ready   (pcs_ready),
        .i_overlap (ovl),
        .o_valid   (pcs_valid),
        .i_ready   (emt_ready),
        .o_group   (grp)
    );

    rcs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pcs_valid),
        .o_ready     (emt_ready),
        .i_group     (grp),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_res_valid (m_axis_tuser)
    );

endmodule

FILE: tb/rect_clip_and_subtract_tb.sv
// ----------------------------------------------------------------------------
// rect_clip_and_subtract_tb
// Self-checking bench for the rectangle clip / subtract block. Directed
// corner rectangles, then random pairs (mostly small overlapping ones) are
// streamed in with random gaps on both sides. A scoreboard class predicts the
// result rectangles of every accepted input and checks them in order.
// ----------------------------------------------------------------------------
module rect_clip_and_subtract_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 226;
    localparam int IDLE_PCT     = 34;
    localparam int CMIN         = 32'sh8000_0000;
    localparam int CMAX         = 32'sh7FFF_FFFF;

    // One rectangle as it sits on the bus, x in the lowest bits
    typedef struct packed {
        rcs_pkg::t_field h;
        rcs_pkg::t_field w;
        rcs_pkg::t_field y;
        rcs_pkg::t_field x;
    } t_rect_word;

    // Wide copy of a rectangle so sums never wrap
    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } t_span;

    typedef struct {
        t_rect_word box;
        logic       valid;
        logic       last;
    } t_res_item;

    // ------------------------------------------------------------------
    // Expected result rectangles and their check
    // ------------------------------------------------------------------
    class rect_result_check;
        t_res_item expected_rects[$];
        int        bad_results = 0;

        function longint widen(rcs_pkg::t_field f);
            rcs_pkg::t_coord c;
            c = f[rcs_pkg::COORD_BITS-1:0];
            return longint'(c);
        endfunction

        function rcs_pkg::t_field narrow(longint v);
            rcs_pkg::t_coord c;
            c = v[rcs_pkg::COORD_BITS-1:0];
            return rcs_pkg::t_field'(c);
        endfunction

        function bit in_range(longint v);
            return v >= -(longint'(1) <<< (rcs_pkg::COORD_BITS - 1)) &&
                   v <   (longint'(1) <<< (rcs_pkg::COORD_BITS - 1));
        endfunction

        function bit empty_box(t_span r);
            return r.w <= 0 || r.h <= 0;
        endfunction

        function t_span to_span(t_rect_word r);
            t_span s;
            s.x = widen(r.x);
            s.y = widen(r.y);
            s.w = widen(r.w);
            s.h = widen(r.h);
            return s;
        endfunction

        // Intersection; 0 when empty, out of range or either side empty
        function bit overlap(t_span a, t_span b, output t_span o);
            longint ar, ab, br, bb, l, t, r, bo;
            o = '{0, 0, 0, 0};
            if (empty_box(a) || empty_box(b)) return 0;
            ar = a.x + a.w;
            ab = a.y + a.h;
            br = b.x + b.w;
            bb = b.y + b.h;
            if (!in_range(ar) || !in_range(ab) || !in_range(br) || !in_range(bb))
                return 0;
            l  = (a.x > b.x) ? a.x : b.x;
            t  = (a.y > b.y) ? a.y : b.y;
            r  = (ar < br) ? ar : br;
            bo = (ab < bb) ? ab : bb;
            if (r <= l || bo <= t) return 0;
            if (!in_range(r - l) || !in_range(bo - t)) return 0;
            o = '{l, t, r - l, bo - t};
            return 1;
        endfunction

        function void store_rect(t_span r, bit valid, bit last);
            t_res_item e;
            e.box.x = valid ? narrow(r.x) : '0;
            e.box.y = valid ? narrow(r.y) : '0;
            e.box.w = valid ? narrow(r.w) : '0;
            e.box.h = valid ? narrow(r.h) : '0;
            e.valid = valid;
            e.last  = last;
            expected_rects.push_back(e);
        endfunction

        // Accepted input transaction: queue the rectangles it must produce
        function void note_item(logic mode, t_rect_word a_in, t_rect_word b_in);
            t_span a, b, c;
            t_span zero = '{0, 0, 0, 0};
            t_span pieces[$];
            bit    ok;
            a  = to_span(a_in);
            b  = to_span(b_in);
            ok = overlap(a, b, c);
            if (mode == rcs_pkg::MODE_CLIP) begin
                // a failed overlap leaves c all zero
                store_rect(c, ok, 1'b1);
            end else if (empty_box(a)) begin
                store_rect(zero, 1'b0, 1'b1);
            end else if (!ok) begin
                store_rect(a, 1'b1, 1'b1);
            end else begin
                // top, bottom, left, right
                if (c.y > a.y)
                    pieces.push_back(t_span'{a.x, a.y, a.w, c.y - a.y});
                if (c.y + c.h < a.y + a.h)
                    pieces.push_back(t_span'{a.x, c.y + c.h, a.w,
                                             (a.y + a.h) - (c.y + c.h)});
                if (c.x > a.x)
                    pieces.push_back(t_span'{a.x, c.y, c.x - a.x, c.h});
                if (c.x + c.w < a.x + a.w)
                    pieces.push_back(t_span'{c.x + c.w, c.y,
                                             (a.x + a.w) - (c.x + c.w), c.h});
                if (pieces.size() == 0)
                    store_rect(zero, 1'b0, 1'b1);
                foreach (pieces[k])
                    store_rect(pieces[k], 1'b1, k == pieces.size() - 1);
            end
        endfunction

        function string show(t_rect_word r, logic valid, logic last);
            return $sformatf("x=%0d y=%0d w=%0d h=%0d v=%b l=%b",
                             r.x, r.y, r.w, r.h, valid, last);
        endfunction

        function void check_rect(t_rect_word got, logic valid, logic last);
            t_res_item want;
            if (expected_rects.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result %s", show(got, valid, last));
                return;
            end
            want = expected_rects.pop_front();
            if (got.x !== want.box.x || got.y !== want.box.y ||
                got.w !== want.box.w || got.h !== want.box.h ||
                valid !== want.valid || last !== want.last) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("mismatch: exp %s, got %s",
                             show(want.box, want.valid, want.last),
                             show(got, valid, last));
            end
        endfunction

        function int pending();
            return expected_rects.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals, DUT, clock
    // ------------------------------------------------------------------
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
    logic [rcs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                              s_axis_tuser  = 1'b0; // mode
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [rcs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;         // res_x, res_y, res_w, res_h
    logic                              m_axis_tuser;         // res_valid
    logic                              m_axis_tlast;         // res_last

    rect_result_check results = new();
    int               src_idle_pct = IDLE_PCT;
    int               cycle_count  = 0;

    rect_clip_and_subtract DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one transaction after a random gap; returns once it is taken
    task automatic offer_item(input logic mode, input t_rect_word a, input t_rect_word b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        results.note_item(mode, a, b);
    endtask

    task automatic offer_fields(input logic mode, input int ax, input int ay, input int aw,
                                input int ah, input int bx, input int by, input int bw,
                                input int bh);
        offer_item(mode, t_rect_word'{ah, aw, ay, ax}, t_rect_word'{bh, bw, by, bx});
    endtask

    // Stop offering until every queued result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results.pending() != 0);
    endtask

    function automatic rcs_pkg::t_field extreme_value();
        case ($urandom_range(5))
            0:       return CMIN + int'($urandom_range(64));
            1:       return CMAX - int'($urandom_range(64));
            2:       return int'($urandom_range(64));
            3:       return -int'($urandom_range(64));
            4:       return 32'sh4000_0000 - int'($urandom_range(64));
            default: return $urandom;
        endcase
    endfunction

    // Random rectangle pair, shaped toward overlapping non-empty pairs
    task automatic pick_pair(output logic mode, output t_rect_word a, output t_rect_word b);
        int kind;
        kind = $urandom_range(99);
        mode = $urandom_range(1) ? rcs_pkg::MODE_SUB : rcs_pkg::MODE_CLIP;
        a.x  = int'($urandom_range(80)) - 40;
        a.y  = int'($urandom_range(80)) - 40;
        a.w  = int'($urandom_range(60)) + 1;
        a.h  = int'($urandom_range(60)) + 1;
        b.x  = int'($urandom_range(80)) - 40;
        b.y  = int'($urandom_range(80)) - 40;
        b.w  = int'($urandom_range(60)) + 1;
        b.h  = int'($urandom_range(60)) + 1;
        if (kind < 55) begin
            // small overlapping-ish pair as set above
        end else if (kind < 65) begin
            // B around A or just inside it
            if ($urandom_range(1)) begin
                b.x = a.x - int'($urandom_range(3));
                b.y = a.y - int'($urandom_range(3));
                b.w = a.w + 6;
                b.h = a.h + 6;
            end else begin
                b.x = a.x + int'($urandom_range(1, 3));
                b.y = a.y + int'($urandom_range(1, 3));
                b.w = a.w - int'($urandom_range(2, 6));
                b.h = a.h - int'($urandom_range(2, 6));
            end
        end else if (kind < 75) begin
            // one empty size
            case ($urandom_range(3))
                0: a.w = -int'($urandom_range(3));
                1: a.h = ($urandom_range(1)) ? CMIN : 0;
                2: b.w = -int'($urandom_range(3));
                default: b.h = ($urandom_range(1)) ? CMIN : 0;
            endcase
        end else if (kind < 88) begin
            a = t_rect_word'{extreme_value(), extreme_value(), extreme_value(),
                             extreme_value()};
            b = t_rect_word'{extreme_value(), extreme_value(), extreme_value(),
                             extreme_value()};
        end else begin
            a = t_rect_word'{$urandom, $urandom, $urandom, $urandom};
            b = t_rect_word'{$urandom, $urandom, $urandom, $urandom};
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic       mode;
        t_rect_word a, b;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // clip: overlap, disjoint, touching, empty sides, end overflow, full range
        offer_fields(rcs_pkg::MODE_CLIP, 0, 0, 10, 10, 5, 5, 10, 10);
        offer_fields(rcs_pkg::MODE_CLIP, 0, 0, 10, 10, 20, 20, 5, 5);
        offer_fields(rcs_pkg::MODE_CLIP, 0, 0, 10, 10, 10, 0, 5, 5);
        offer_fields(rcs_pkg::MODE_CLIP, 0, 0, 0, 10, 0, 0, 10, 10);
        offer_fields(rcs_pkg::MODE_CLIP, 0, 0, 10, 10, 0, 0, 10, -5);
        offer_fields(rcs_pkg::MODE_CLIP, CMAX - 15, 0, 32, 10, CMAX - 20, 0, 10, 10);
        offer_fields(rcs_pkg::MODE_CLIP, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
        offer_fields(rcs_pkg::MODE_CLIP, -10, -10, 30, 30, -2, -3, 4, 5);
        offer_fields(rcs_pkg::MODE_CLIP, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        offer_fields(rcs_pkg::MODE_CLIP, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        offer_fields(rcs_pkg::MODE_CLIP, -1, -1, -1, -1, -1, -1, -1, -1);
        // subtract: empty A, empty or disjoint B, B covering A
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 0, 0, 0, 10, 10);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, CMIN, 10, 0, 0, 10, 10);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, 2, 2, 0, 4);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, 40, 40, 4, 4);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, -1, -1, 12, 12);
        // subtract: all four pieces, then each piece alone
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, 3, 3, 4, 4);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, -5, 5, 20, 20);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, -5, -5, 20, 10);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, 5, -5, 20, 20);
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, -5, -5, 10, 20);
        // subtract: B or A end coordinate overflows, then a wide A around a small B
        offer_fields(rcs_pkg::MODE_SUB, 0, 0, 10, 10, CMAX - 2, 0, 8, 8);
        offer_fields(rcs_pkg::MODE_SUB, CMAX - 5, CMIN, 10, 10, CMAX - 5, CMIN, 2, 2);
        offer_fields(rcs_pkg::MODE_SUB, CMIN, CMIN, CMAX, CMAX, 0, 0, 1, 1);
        wait_drained();

        // Random part: first a stretch with no input gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            src_idle_pct = (n < 60) ? 0 : IDLE_PCT;
            if (n == 125) wait_drained();
            pick_pair(mode, a, b);
            offer_item(mode, a, b);
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (results.pending() != 0);
        repeat (20) @(posedge i_clk);
        if (results.bad_results == 0 && results.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: check each result transaction, random back-pressure,
    // one long hold-off and a stretch with no stalls
    // ------------------------------------------------------------------
    initial begin : result_sink
        int seen      = 0;
        int hold_left = 0;
        bit held      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                results.check_rect(t_rect_word'(m_axis_tdata), m_axis_tuser, m_axis_tlast);
                seen++;
            end
            if (!held && seen >= 80) begin
                held      = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (seen >= 160 && seen < 320) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

endmodule

FILE: sim.f
design/rcs_pkg.sv
design/rcs_bounds.sv
design/rcs_overlap.sv
design/rcs_pieces.sv
design/rcs_emit.sv
design/rect_clip_and_subtract.sv
tb/rect_clip_and_subtract_tb.sv
